// ===== design/lcs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcs_pkg: shared widths and types for the limb clip segment block
// Fixed-point widths derived from FRAC_BITS and COORD_BITS, and the structs
// that travel along the divider, normaliser and square-root cell chains.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int COORD_BITS = 16;

  localparam int IN_W  = 16;                        // input field width
  localparam int R_W   = 15;                        // disc radius width
  localparam int OUT_W = 16;                        // output coordinate width

  // crossing point: |num| <= 2^31, quotient saturates to 2^XQ_W - 1
  localparam int MAG_W  = 2 * IN_W;
  localparam int XQ_W   = COORD_BITS - 1 + FRAC_BITS;
  localparam int NUM_W  = MAG_W + FRAC_BITS + 1;
  localparam int DEN_W  = IN_W + 1;
  localparam int HI_W   = NUM_W - XQ_W;
  localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;

  // normalisation to a leading one at bit NORM_W - 1
  localparam int NORM_W = 30;
  localparam int NW     = (XQ_W > NORM_W) ? XQ_W : NORM_W;
  localparam int NSH    = $clog2(NW);

  // length of the normalised vector
  localparam int SQ_W   = 2 * NORM_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int RAD_W  = SUM_W + 1;
  localparam int ROOT_W = RAD_W / 2;
  localparam int RREM_W = ROOT_W + 2;

  // radius rescale: q = round(r * a / len), q <= r
  localparam int PR_W   = R_W + NORM_W;
  localparam int N2_W   = PR_W + 2;
  localparam int Q_W    = OUT_W;
  localparam int D2_W   = ROOT_W + 1;

  localparam logic [R_W-1:0] RADIUS_RESET = R_W'(256);

  typedef struct packed {
    logic ok;     // depths differ
    logic sx;     // sign of the x crossing
    logic sy;     // sign of the y crossing
    logic ovx;    // x crossing beyond range
    logic ovy;    // y crossing beyond range
    logic zero;   // crossing sits at the centre
  } lcs_tag_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rx;
    logic [XQ_W-1:0]  accx;
    logic [DEN_W-1:0] ry;
    logic [XQ_W-1:0]  accy;
  } lcs_div_t;

  typedef struct packed {
    logic [RREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
    logic [NORM_W-1:0] ax;
    logic [NORM_W-1:0] ay;
  } lcs_root_t;

  typedef struct packed {
    logic [D2_W-1:0] den;
    logic [D2_W-1:0] rx;
    logic [Q_W-1:0]  qx;
    logic [D2_W-1:0] ry;
    logic [Q_W-1:0]  qy;
  } lcs_scale_t;

endpackage

// ===== design/lcs_cross_cell.sv =====
// ----------------------------------------------------------------------------
// lcs_cross_cell: one quotient bit of the crossing-point division
// Restoring division step on both axes against a shared divisor.
// ----------------------------------------------------------------------------
module lcs_cross_cell import lcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     in_valid,
  input  lcs_tag_t in_tag,
  input  lcs_div_t in_data,
  output logic     out_valid,
  output lcs_tag_t out_tag,
  output lcs_div_t out_data
);

  logic [DEN_W:0] shx, shy;
  logic           gex, gey;
  lcs_div_t       nxt;

  assign shx = {in_data.rx, in_data.accx[XQ_W-1]};
  assign shy = {in_data.ry, in_data.accy[XQ_W-1]};
  assign gex = shx >= {1'b0, in_data.den};
  assign gey = shy >= {1'b0, in_data.den};

  always_comb begin
    nxt      = in_data;
    nxt.rx   = gex ? DEN_W'(shx - {1'b0, in_data.den}) : shx[DEN_W-1:0];
    nxt.ry   = gey ? DEN_W'(shy - {1'b0, in_data.den}) : shy[DEN_W-1:0];
    nxt.accx = {in_data.accx[XQ_W-2:0], gex};
    nxt.accy = {in_data.accy[XQ_W-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag  <= in_tag;
      out_data <= nxt;
    end
  end

endmodule

// ===== design/lcs_norm.sv =====
// ----------------------------------------------------------------------------
// lcs_norm: joint normaliser for the crossing magnitudes
// Binary-weighted shift stages put the leading one of the pair at the top.
// ----------------------------------------------------------------------------
module lcs_norm import lcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  lcs_tag_t          in_tag,
  input  logic [NW-1:0]     in_ax,
  input  logic [NW-1:0]     in_ay,
  output logic              out_valid,
  output lcs_tag_t          out_tag,
  output logic [NORM_W-1:0] out_ax,
  output logic [NORM_W-1:0] out_ay
);

  logic          st_v  [NSH+1];
  lcs_tag_t      st_t  [NSH+1];
  logic [NW-1:0] st_ax [NSH+1];
  logic [NW-1:0] st_ay [NSH+1];

  assign st_v[0]  = in_valid;
  assign st_t[0]  = in_tag;
  assign st_ax[0] = in_ax;
  assign st_ay[0] = in_ay;

  for (genvar i = 0; i < NSH; i++) begin : g_stage
    localparam int SH = 1 << (NSH - 1 - i);
    logic top_zero;

    // shift when the top SH bits of both axes are clear
    assign top_zero = ((st_ax[i] | st_ay[i]) >> (NW - SH)) == '0;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[i+1] <= 1'b0;
      end else if (adv) begin
        st_v[i+1] <= st_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_t[i+1]  <= st_t[i];
        st_ax[i+1] <= top_zero ? (st_ax[i] << SH) : st_ax[i];
        st_ay[i+1] <= top_zero ? (st_ay[i] << SH) : st_ay[i];
      end
    end
  end

  assign out_valid = st_v[NSH];
  assign out_tag   = st_t[NSH];
  assign out_ax    = st_ax[NSH][NW-1 -: NORM_W];
  assign out_ay    = st_ay[NSH][NW-1 -: NORM_W];

endmodule

// ===== design/lcs_root_cell.sv =====
// ----------------------------------------------------------------------------
// lcs_root_cell: one result bit of the integer square root
// Digit-by-digit root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module lcs_root_cell import lcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_valid,
  input  lcs_tag_t  in_tag,
  input  lcs_root_t in_data,
  output logic      out_valid,
  output lcs_tag_t  out_tag,
  output lcs_root_t out_data
);

  logic [RREM_W+1:0] rem2;
  logic [RREM_W+1:0] trial;
  logic              ge;
  lcs_root_t         nxt;

  assign rem2  = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
  assign trial = (RREM_W + 2)'({in_data.root, 2'b01});
  assign ge    = rem2 >= trial;

  always_comb begin
    nxt      = in_data;
    nxt.rem  = ge ? RREM_W'(rem2 - trial) : rem2[RREM_W-1:0];
    nxt.root = {in_data.root[ROOT_W-2:0], ge};
    nxt.rad  = {in_data.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag  <= in_tag;
      out_data <= nxt;
    end
  end

endmodule

// ===== design/lcs_scale_cell.sv =====
// ----------------------------------------------------------------------------
// lcs_scale_cell: one quotient bit of the radius rescale division
// Restoring division step on both axes against the doubled length.
// ----------------------------------------------------------------------------
module lcs_scale_cell import lcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  logic       in_valid,
  input  lcs_tag_t   in_tag,
  input  lcs_scale_t in_data,
  output logic       out_valid,
  output lcs_tag_t   out_tag,
  output lcs_scale_t out_data
);

  logic [D2_W:0] shx, shy;
  logic          gex, gey;
  lcs_scale_t    nxt;

  assign shx = {in_data.rx, in_data.qx[Q_W-1]};
  assign shy = {in_data.ry, in_data.qy[Q_W-1]};
  assign gex = shx >= {1'b0, in_data.den};
  assign gey = shy >= {1'b0, in_data.den};

  always_comb begin
    nxt    = in_data;
    nxt.rx = gex ? D2_W'(shx - {1'b0, in_data.den}) : shx[D2_W-1:0];
    nxt.ry = gey ? D2_W'(shy - {1'b0, in_data.den}) : shy[D2_W-1:0];
    nxt.qx = {in_data.qx[Q_W-2:0], gex};
    nxt.qy = {in_data.qy[Q_W-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag  <= in_tag;
      out_data <= nxt;
    end
  end

endmodule

// ===== design/limb_clip_segment.sv =====
// ----------------------------------------------------------------------------
// limb_clip_segment: clip a projected outline segment at the globe limb
// Finds the zero-depth crossing of a segment and pushes it onto the disc.
// ----------------------------------------------------------------------------
// Takes one segment beat per clock and returns one limb beat per segment, in
// order. The work is a single pipeline that moves as a whole and holds three
// chains of one-bit cells: XQ_W cells for the crossing division, ROOT_W cells
// for the square root and Q_W cells for the radius rescale. Throughput is one
// beat per cycle whenever limb_stall is low; while a result sits stalled at
// the output the whole pipeline holds and item_stall rises. disc_radius is
// taken from the register when a beat reaches the rescale multiplier, so
// write it only with the pipeline empty. Equal depths give ok = 0 and a zero
// point; a crossing at the exact centre comes out as (0, 0) with ok = 1.
// ----------------------------------------------------------------------------
module limb_clip_segment import lcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [R_W-1:0]         cfg_wdata,
  // segment channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic signed [IN_W-1:0] visible_depth,
  input  logic signed [IN_W-1:0] visible_x,
  input  logic signed [IN_W-1:0] visible_y,
  input  logic signed [IN_W-1:0] hidden_depth,
  input  logic signed [IN_W-1:0] hidden_x,
  input  logic signed [IN_W-1:0] hidden_y,
  // limb point channel
  output logic                   limb_valid,
  input  logic                   limb_stall,
  output logic                   ok,
  output logic signed [OUT_W-1:0] limb_x,
  output logic signed [OUT_W-1:0] limb_y
);

  // advance the whole pipeline unless a finished beat is held at the output
  logic adv;
  assign adv        = !(limb_valid && limb_stall);
  assign item_stall = !adv;

  // --------------------------------------------------------------------------
  // radius register
  // --------------------------------------------------------------------------
  logic [R_W-1:0] disc_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      disc_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      disc_radius <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: cross products and depth span
  // numerator reduces to vd*h - hd*v, so each axis needs two 16x16 products
  // --------------------------------------------------------------------------
  logic                      s1_v;
  logic signed [MAG_W-1:0]   s1_pvx, s1_phx, s1_pvy, s1_phy;
  logic signed [IN_W:0]      s1_span;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pvx  <= visible_depth * hidden_x;
      s1_phx  <= hidden_depth * visible_x;
      s1_pvy  <= visible_depth * hidden_y;
      s1_phy  <= hidden_depth * visible_y;
      s1_span <= {visible_depth[IN_W-1], visible_depth}
               - {hidden_depth[IN_W-1], hidden_depth};
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: magnitudes, rounded dividend, range check of the quotient
  // --------------------------------------------------------------------------
  logic signed [MAG_W:0] nx, ny;
  logic [MAG_W-1:0]      magx, magy;
  logic [IN_W-1:0]       smag;
  logic [NUM_W-1:0]      numx, numy;
  logic [DEN_W-1:0]      den;
  logic [CMP_W-1:0]      hix, hiy, den_c;
  lcs_tag_t              s2_tag;
  lcs_div_t              s2_div;

  assign nx    = {s1_pvx[MAG_W-1], s1_pvx} - {s1_phx[MAG_W-1], s1_phx};
  assign ny    = {s1_pvy[MAG_W-1], s1_pvy} - {s1_phy[MAG_W-1], s1_phy};
  assign magx  = nx[MAG_W] ? MAG_W'(-nx) : nx[MAG_W-1:0];
  assign magy  = ny[MAG_W] ? MAG_W'(-ny) : ny[MAG_W-1:0];
  assign smag  = s1_span[IN_W] ? IN_W'(-s1_span) : s1_span[IN_W-1:0];
  // 2 * (|n| << FRAC_BITS) + span gives round half away after flooring
  assign numx  = {magx, {FRAC_BITS{1'b0}}, 1'b0} + NUM_W'(smag);
  assign numy  = {magy, {FRAC_BITS{1'b0}}, 1'b0} + NUM_W'(smag);
  assign den   = {smag, 1'b0};
  assign hix   = CMP_W'(numx[NUM_W-1:XQ_W]);
  assign hiy   = CMP_W'(numy[NUM_W-1:XQ_W]);
  assign den_c = CMP_W'(den);

  always_comb begin
    s2_tag.ok   = s1_span != '0;
    s2_tag.sx   = nx[MAG_W] ^ s1_span[IN_W];
    s2_tag.sy   = ny[MAG_W] ^ s1_span[IN_W];
    // quotient would not fit XQ_W bits: clamp it instead
    s2_tag.ovx  = hix >= den_c;
    s2_tag.ovy  = hiy >= den_c;
    s2_tag.zero = 1'b0;
    s2_div.den  = den;
    s2_div.rx   = hix[DEN_W-1:0];
    s2_div.accx = numx[XQ_W-1:0];
    s2_div.ry   = hiy[DEN_W-1:0];
    s2_div.accy = numy[XQ_W-1:0];
  end

  // --------------------------------------------------------------------------
  // crossing division: XQ_W cells, one quotient bit each
  // --------------------------------------------------------------------------
  logic     cr_v [XQ_W+1];
  lcs_tag_t cr_t [XQ_W+1];
  lcs_div_t cr_d [XQ_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cr_v[0] <= 1'b0;
    end else if (adv) begin
      cr_v[0] <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr_t[0] <= s2_tag;
      cr_d[0] <= s2_div;
    end
  end

  for (genvar i = 0; i < XQ_W; i++) begin : g_cross
    lcs_cross_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (cr_v[i]),
      .in_tag    (cr_t[i]),
      .in_data   (cr_d[i]),
      .out_valid (cr_v[i+1]),
      .out_tag   (cr_t[i+1]),
      .out_data  (cr_d[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // clamp, centre test, hand over to the normaliser
  // --------------------------------------------------------------------------
  logic [XQ_W-1:0] qx, qy;
  lcs_tag_t        c_tag;
  logic            n0_v;
  lcs_tag_t        n0_t;
  logic [NW-1:0]   n0_ax, n0_ay;

  assign qx = cr_t[XQ_W].ovx ? '1 : cr_d[XQ_W].accx;
  assign qy = cr_t[XQ_W].ovy ? '1 : cr_d[XQ_W].accy;

  always_comb begin
    c_tag      = cr_t[XQ_W];
    c_tag.zero = (qx == '0) && (qy == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n0_v <= 1'b0;
    end else if (adv) begin
      n0_v <= cr_v[XQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n0_t  <= c_tag;
      n0_ax <= NW'(qx);
      n0_ay <= NW'(qy);
    end
  end

  logic              nm_v;
  lcs_tag_t          nm_t;
  logic [NORM_W-1:0] nm_ax, nm_ay;

  lcs_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (n0_v),
    .in_tag    (n0_t),
    .in_ax     (n0_ax),
    .in_ay     (n0_ay),
    .out_valid (nm_v),
    .out_tag   (nm_t),
    .out_ax    (nm_ax),
    .out_ay    (nm_ay)
  );

  // --------------------------------------------------------------------------
  // squares, then the sum that seeds the root chain
  // --------------------------------------------------------------------------
  logic              sq_v;
  lcs_tag_t          sq_t;
  logic [SQ_W-1:0]   sq_x, sq_y;
  logic [NORM_W-1:0] sq_ax, sq_ay;
  lcs_root_t         rt_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
    end else if (adv) begin
      sq_v <= nm_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_t  <= nm_t;
      sq_x  <= nm_ax * nm_ax;
      sq_y  <= nm_ay * nm_ay;
      sq_ax <= nm_ax;
      sq_ay <= nm_ay;
    end
  end

  always_comb begin
    rt_seed.rem  = '0;
    rt_seed.root = '0;
    rt_seed.rad  = RAD_W'(SUM_W'(sq_x) + SUM_W'(sq_y));
    rt_seed.ax   = sq_ax;
    rt_seed.ay   = sq_ay;
  end

  // --------------------------------------------------------------------------
  // square root: ROOT_W cells, one root bit each
  // --------------------------------------------------------------------------
  logic      rt_v [ROOT_W+1];
  lcs_tag_t  rt_t [ROOT_W+1];
  lcs_root_t rt_d [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_v[0] <= 1'b0;
    end else if (adv) begin
      rt_v[0] <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_t[0] <= sq_t;
      rt_d[0] <= rt_seed;
    end
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    lcs_root_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (rt_v[i]),
      .in_tag    (rt_t[i]),
      .in_data   (rt_d[i]),
      .out_valid (rt_v[i+1]),
      .out_tag   (rt_t[i+1]),
      .out_data  (rt_d[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // radius multiply, then the rounded dividend of the rescale
  // --------------------------------------------------------------------------
  logic              pm_v;
  lcs_tag_t          pm_t;
  logic [PR_W-1:0]   pm_x, pm_y;
  logic [ROOT_W-1:0] pm_len;
  logic [N2_W-1:0]   n2x, n2y;
  lcs_scale_t        sc_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      pm_v <= 1'b0;
    end else if (adv) begin
      pm_v <= rt_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pm_t   <= rt_t[ROOT_W];
      pm_x   <= disc_radius * rt_d[ROOT_W].ax;
      pm_y   <= disc_radius * rt_d[ROOT_W].ay;
      pm_len <= rt_d[ROOT_W].root;
    end
  end

  // 2*r*a + len over 2*len rounds half away
  assign n2x = {pm_x, 1'b0} + N2_W'(pm_len);
  assign n2y = {pm_y, 1'b0} + N2_W'(pm_len);

  always_comb begin
    sc_seed.den = {pm_len, 1'b0};
    sc_seed.rx  = D2_W'(n2x[N2_W-1:Q_W]);
    sc_seed.qx  = n2x[Q_W-1:0];
    sc_seed.ry  = D2_W'(n2y[N2_W-1:Q_W]);
    sc_seed.qy  = n2y[Q_W-1:0];
  end

  // --------------------------------------------------------------------------
  // rescale division: Q_W cells, one quotient bit each
  // --------------------------------------------------------------------------
  logic       sc_v [Q_W+1];
  lcs_tag_t   sc_t [Q_W+1];
  lcs_scale_t sc_d [Q_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_v[0] <= 1'b0;
    end else if (adv) begin
      sc_v[0] <= pm_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_t[0] <= pm_t;
      sc_d[0] <= sc_seed;
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_scale
    lcs_scale_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (sc_v[i]),
      .in_tag    (sc_t[i]),
      .in_data   (sc_d[i]),
      .out_valid (sc_v[i+1]),
      .out_tag   (sc_t[i+1]),
      .out_data  (sc_d[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // output register: apply signs, drop the point for equal depths or centre
  // the quotient never exceeds the radius, so no saturation is needed
  // --------------------------------------------------------------------------
  lcs_tag_t         f_t;
  logic             f_drop;
  logic [OUT_W-1:0] fx, fy;

  assign f_t    = sc_t[Q_W];
  assign f_drop = !f_t.ok || f_t.zero;
  assign fx     = f_t.sx ? OUT_W'(-sc_d[Q_W].qx) : sc_d[Q_W].qx;
  assign fy     = f_t.sy ? OUT_W'(-sc_d[Q_W].qy) : sc_d[Q_W].qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      limb_valid <= 1'b0;
    end else if (adv) begin
      limb_valid <= sc_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok     <= f_t.ok;
      limb_x <= f_drop ? '0 : fx;
      limb_y <= f_drop ? '0 : fy;
    end
  end

endmodule

// ===== tb/limb_clip_segment_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limb_clip_segment_chk: limb point scoreboard
// Watches the segment and limb channels. For each accepted segment beat it
// works out the clipped limb point and compares it with the output beats, in
// order.
// ----------------------------------------------------------------------------
module limb_clip_segment_chk import lcs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [R_W-1:0]          cfg_wdata,
  input  logic                    item_valid,
  input  logic                    item_stall,
  input  logic signed [IN_W-1:0]  visible_depth,
  input  logic signed [IN_W-1:0]  visible_x,
  input  logic signed [IN_W-1:0]  visible_y,
  input  logic signed [IN_W-1:0]  hidden_depth,
  input  logic signed [IN_W-1:0]  hidden_x,
  input  logic signed [IN_W-1:0]  hidden_y,
  input  logic                    limb_valid,
  input  logic                    limb_stall,
  input  logic                    ok,
  input  logic signed [OUT_W-1:0] limb_x,
  input  logic signed [OUT_W-1:0] limb_y,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic                    ok;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } limb_pt_t;

  limb_pt_t       limb_due[$];
  logic [R_W-1:0] radius_copy;

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // num / span at FRAC_BITS resolution, rounded half away, clamped
  function automatic longint cross_fix(longint num, longint span);
    longint unsigned m, q, lim;
    m   = abs64(num) << FRAC_BITS;
    lim = (64'd1 << (COORD_BITS - 1 + FRAC_BITS)) - 1;
    q   = (2 * m + span) / (2 * span);
    if (q > lim) q = lim;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[OUT_W-1:0];
  endfunction

  function automatic limb_pt_t clip_limb(longint vd, longint vx, longint vy,
                                         longint hd, longint hx, longint hy,
                                         longint unsigned rad);
    limb_pt_t        p;
    longint          span, nx, ny, xq, yq, ox, oy;
    longint unsigned ax, ay, m, len, qx, qy;
    p    = '0;
    span = vd - hd;
    if (span == 0) return p;
    nx = vx * span + vd * (hx - vx);
    ny = vy * span + vd * (hy - vy);
    if (span < 0) begin
      span = -span;
      nx   = -nx;
      ny   = -ny;
    end
    xq = cross_fix(nx, span);
    yq = cross_fix(ny, span);
    ox = 0;
    oy = 0;
    // a crossing at the very centre keeps (0, 0): no push
    if (xq != 0 || yq != 0) begin
      ax = abs64(xq);
      ay = abs64(yq);
      m  = (ax > ay) ? ax : ay;
      while (m >= (64'd1 << 30)) begin
        ax >>= 1; ay >>= 1; m >>= 1;
      end
      while (m < (64'd1 << 29)) begin
        ax <<= 1; ay <<= 1; m <<= 1;
      end
      len = root_floor(ax * ax + ay * ay);
      qx  = (2 * rad * ax + len) / (2 * len);
      qy  = (2 * rad * ay + len) / (2 * len);
      ox  = (xq < 0) ? -longint'(qx) : longint'(qx);
      oy  = (yq < 0) ? -longint'(qy) : longint'(qy);
    end
    p.ok = 1'b1;
    p.x  = clamp16(ox);
    p.y  = clamp16(oy);
    return p;
  endfunction

  assign pending = limb_due.size();

  always @(posedge clk) begin
    limb_pt_t want;
    if (rst) begin
      radius_copy <= RADIUS_RESET;
      fail_count  <= 0;
      limb_due.delete();
    end else begin
      if (cfg_we) radius_copy <= cfg_wdata;
      if (item_valid && !item_stall)
        limb_due.push_back(clip_limb(visible_depth, visible_x, visible_y,
                                     hidden_depth, hidden_x, hidden_y,
                                     radius_copy));
      if (limb_valid && !limb_stall) begin
        if (limb_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected limb beat ok=%0d x=%0d y=%0d", ok, limb_x, limb_y);
          fail_count <= fail_count + 1;
        end else begin
          want = limb_due.pop_front();
          if (want.ok !== ok || want.x !== limb_x || want.y !== limb_y) begin
            if (fail_count < 10)
              $display("limb mismatch: want ok=%0d x=%0d y=%0d, got ok=%0d x=%0d y=%0d",
                       want.ok, want.x, want.y, ok, limb_x, limb_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/limb_clip_segment_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limb_clip_segment_tb: limb clip segment testbench
// Feeds directed and random segments through the block over several disc
// radii and idling patterns; a scoreboard module checks every limb point.
// ----------------------------------------------------------------------------
module limb_clip_segment_tb;
  import lcs_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [R_W-1:0]          cfg_wdata = '0;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  logic signed [IN_W-1:0]  visible_depth = '0;
  logic signed [IN_W-1:0]  visible_x = '0;
  logic signed [IN_W-1:0]  visible_y = '0;
  logic signed [IN_W-1:0]  hidden_depth = '0;
  logic signed [IN_W-1:0]  hidden_x = '0;
  logic signed [IN_W-1:0]  hidden_y = '0;
  logic                    limb_valid;
  logic                    limb_stall = 1'b0;
  logic                    ok;
  logic signed [OUT_W-1:0] limb_x;
  logic signed [OUT_W-1:0] limb_y;
  int                      fail_count;
  int                      pending;

  // idling percentages of the current phase
  int                      send_idle_pct = 0;
  int                      recv_stall_pct = 0;

  always #5 clk = ~clk;

  limb_clip_segment u_top (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .item_valid, .item_stall,
    .visible_depth, .visible_x, .visible_y,
    .hidden_depth, .hidden_x, .hidden_y,
    .limb_valid, .limb_stall, .ok, .limb_x, .limb_y
  );

  limb_clip_segment_chk u_chk (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .item_valid, .item_stall,
    .visible_depth, .visible_x, .visible_y,
    .hidden_depth, .hidden_x, .hidden_y,
    .limb_valid, .limb_stall, .ok, .limb_x, .limb_y,
    .fail_count, .pending
  );

  // Receiver: decide the stall once per cycle, on the falling edge.
  always @(negedge clk) begin
    limb_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Offer one segment beat and hold it until the block takes it, then drop
  // valid for a random gap if the phase asks for sender idling.
  task automatic send_segment(input int vd, vx, vy, hd, hx, hy);
    visible_depth = vd[15:0];
    visible_x     = vx[15:0];
    visible_y     = vy[15:0];
    hidden_depth  = hd[15:0];
    hidden_x      = hx[15:0];
    hidden_y      = hy[15:0];
    item_valid    = 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid = 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
      @(negedge clk);
    end
  endtask

  // Drain the pipeline, let it settle past its latency, then write the radius.
  task automatic set_radius(input logic [R_W-1:0] rad);
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = rad;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic int span_rand(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Mostly segments that truly cross the limb, with some near-equal and equal
  // depths and some raw noise across the whole field range.
  task automatic random_segment();
    int kind, vd, hd;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      vd = $urandom_range(1, 16384);
      hd = -int'($urandom_range(0, 16384));
      if ($urandom_range(0, 1)) begin
        vd = -vd;
        hd = -hd;
      end
      send_segment(vd, span_rand(2000), span_rand(2000), hd,
                   span_rand(2000), span_rand(2000));
    end else if (kind == 6) begin
      vd = span_rand(32000);
      send_segment(vd, span_rand(32768), span_rand(32768), vd + span_rand(3),
                   span_rand(32768), span_rand(32768));
    end else if (kind == 7) begin
      vd = span_rand(32768);
      send_segment(vd, span_rand(32768), span_rand(32768), vd,
                   span_rand(32768), span_rand(32768));
    end else begin
      send_segment(span_rand(32768), span_rand(32768), span_rand(32768),
                   span_rand(32768), span_rand(32768), span_rand(32768));
    end
  endtask

  logic [R_W-1:0] radius_plan [8];

  initial begin
    radius_plan = '{15'd256, 15'd0, 15'd32767, 15'd1, 15'd100, 15'd0, 15'd0, 15'd0};
    radius_plan[5] = $urandom_range(0, 32767);
    radius_plan[6] = $urandom_range(0, 32767);
    radius_plan[7] = $urandom_range(0, 32767);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      set_radius(radius_plan[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (ph == 0 || ph == 1) begin
        // typical crossing, then equal depths
        send_segment(16384, 100, -50, -16384, 300, 70);
        send_segment(5, 1, 2, 5, 3, 4);
        send_segment(-32768, 32767, -32768, -32768, -32768, 32767);
        // crossing lands on the centre
        send_segment(100, 0, 0, -100, 0, 0);
        send_segment(100, -50, 20, -100, 50, -20);
        // field extremes
        send_segment(32767, 32767, 32767, -32768, -32768, -32768);
        send_segment(-32768, -32768, 32767, 32767, 32767, -32768);
        // far crossing, clamped per axis before the push
        send_segment(32767, -32768, -32768, 32766, 32767, 32767);
        send_segment(-32768, 32767, 32767, -32767, -32768, -32768);
        send_segment(1, 32767, -32768, 0, -32768, 32767);
        send_segment(-1, -32768, 32767, 0, 32767, -32768);
        // negative span, and a crossing on one axis
        send_segment(-100, 10, 20, 200, -30, 40);
        send_segment(50, 0, 500, -50, 0, 700);
        send_segment(50, -400, 0, -50, -600, 0);
      end
      for (int n = 0; n < 155; n++) random_segment();
    end

    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
